### hdl/io_latency_histogram_tracker_assert.svh
// assertion macros for the latency histogram tracker
`ifndef IO_LATENCY_HISTOGRAM_TRACKER_ASSERT_SVH
`define IO_LATENCY_HISTOGRAM_TRACKER_ASSERT_SVH
// assert that an antecedent implies a consequent on the next edge
`define LHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// assert that an expression holds on every edge out of reset
`define LHT_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`endif

### hdl/lht_pkg.sv
// shared types and constants of the latency histogram tracker
package lht_pkg;
   localparam int ModeWidth = 2;
   localparam int TagFieldWidth = 10;
   localparam int StampWidth = 64;
   localparam int BucketFieldWidth = 6;
   localparam int LatencyWidth = 55;
   localparam int OutCountWidth = 32;
   localparam int NsPerUs = 1000;
   // divide by ns-per-us a 16-bit digit at a time: estimate the digit, then update the remainder
   localparam int DivDigit = 16;
   localparam int DivSteps = 8;
   // reciprocal of ns-per-us scaled by 2^DivShift, exact for 26-bit partial dividends
   localparam int DivShift = 36;
   localparam int DivRecip = 68719477;

   typedef enum logic [1:0] {
      MODE_START    = 2'd0,
      MODE_COMPLETE = 2'd1,
      MODE_READ     = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_CHECK,
      ST_DIVIDE,
      ST_HIST_READ,
      ST_UPDATE,
      ST_RESPOND
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic div_start;
      logic div_step;
      logic hist_read;
      logic update;
      logic present;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic match;
      logic div_done;
      logic clearing;
   } status_type;
endpackage

### hdl/lht_ctrl.sv
// controller state machine of the latency histogram tracker
module lht_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_fire,
   input  logic [1:0]             mode,
   input  logic                   out_free,
   input  lht_pkg::status_type    status,
   output logic                   in_ready,
   output lht_pkg::cmd_type       cmd
);
   lht_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lht_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lht_pkg::ST_IDLE: begin
            if (in_fire) state_in = lht_pkg::ST_LOOKUP;
         end
         lht_pkg::ST_LOOKUP: state_in = lht_pkg::ST_CHECK;
         lht_pkg::ST_CHECK: begin
            if (mode == lht_pkg::MODE_COMPLETE && status.match)
               state_in = lht_pkg::ST_DIVIDE;
            else
               state_in = lht_pkg::ST_HIST_READ;
         end
         lht_pkg::ST_DIVIDE: begin
            if (status.div_done) state_in = lht_pkg::ST_HIST_READ;
         end
         lht_pkg::ST_HIST_READ: state_in = lht_pkg::ST_UPDATE;
         lht_pkg::ST_UPDATE:    state_in = lht_pkg::ST_RESPOND;
         lht_pkg::ST_RESPOND: begin
            if (out_free) state_in = lht_pkg::ST_IDLE;
         end
         default: state_in = lht_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         lht_pkg::ST_IDLE: begin
            in_ready = !status.clearing;
            cmd.capture = in_fire;
         end
         lht_pkg::ST_CHECK:     cmd.div_start = 1'b1;
         lht_pkg::ST_DIVIDE:    cmd.div_step = 1'b1;
         lht_pkg::ST_HIST_READ: cmd.hist_read = 1'b1;
         lht_pkg::ST_UPDATE:    cmd.update = 1'b1;
         lht_pkg::ST_RESPOND:   cmd.present = out_free;
         default: ;
      endcase
   end
endmodule

### hdl/lht_datapath.sv
// tag table, histogram memory, counters and divider of the tracker
module lht_datapath #(
   parameter int TAG_COUNT = 1024,
   parameter int BUCKET_COUNT = 64,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lht_pkg::cmd_type                  cmd,
   input  logic [lht_pkg::ModeWidth-1:0]     in_mode,
   input  logic [lht_pkg::TagFieldWidth-1:0] in_tag,
   input  logic [lht_pkg::StampWidth-1:0]    in_stamp,
   input  logic [lht_pkg::BucketFieldWidth-1:0] in_bucket,
   output lht_pkg::status_type               status,
   output logic [1:0]                        cur_mode,
   output logic                              out_matched,
   output logic [lht_pkg::LatencyWidth-1:0]  out_latency,
   output logic [lht_pkg::BucketFieldWidth-1:0] out_bucket,
   output logic [lht_pkg::OutCountWidth-1:0] out_bcount,
   output logic [lht_pkg::OutCountWidth-1:0] out_inflight,
   output logic [lht_pkg::OutCountWidth-1:0] out_completed
);
   localparam int TagBits = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
   localparam int BktBits = $clog2(BUCKET_COUNT);
   localparam int SW = lht_pkg::StampWidth;
   localparam int DW = lht_pkg::DivDigit;
   localparam logic [COUNT_WIDTH-1:0] CntMax = '1;
   localparam logic [BktBits-1:0] BktCap = BktBits'(BUCKET_COUNT - 1);
   localparam int OW = lht_pkg::OutCountWidth;
   localparam int ClrCount = (TAG_COUNT > BUCKET_COUNT) ? TAG_COUNT : BUCKET_COUNT;
   localparam int ClrBits = $clog2(ClrCount) + 1;

   logic [SW-1:0] stamp_mem [TAG_COUNT];
   logic pend_mem [TAG_COUNT];
   logic [COUNT_WIDTH-1:0] hist_mem [BUCKET_COUNT];

   logic [1:0] mode_ff;
   logic [lht_pkg::TagFieldWidth-1:0] tag_ff;
   logic [SW-1:0] now_ff;
   logic [lht_pkg::BucketFieldWidth-1:0] rb_ff;
   logic [SW-1:0] stamp_rd_ff;
   logic tag_ok;
   logic match_ff;
   logic [TagBits-1:0] tag_idx;

   // digit-wise divide by the ns-per-us constant through a reciprocal multiply
   logic [SW-1:0] quo_ff;
   logic [9:0] rem_ff;
   logic [DW-1:0] qd_ff;
   logic [3:0] step_ff;
   logic [25:0] div_num, div_back, div_rem;
   logic [52:0] div_prod;
   logic [BktBits-1:0] bkt_ff, bkt_in;
   logic [COUNT_WIDTH-1:0] hist_rd_ff;
   logic [COUNT_WIDTH-1:0] inflight_ff, completed_ff;
   logic bkt_ok;
   logic [BktBits-1:0] rd_idx;
   logic [ClrBits-1:0] clr_ff;
   logic clearing;

   assign tag_idx = TagBits'(tag_ff);
   assign tag_ok = (32'(tag_ff) < TAG_COUNT);
   assign bkt_ok = (32'(rb_ff) < BUCKET_COUNT);
   assign cur_mode = mode_ff;
   assign clearing = (32'(clr_ff) < ClrCount);
   assign status.match = match_ff;
   assign status.div_done = (step_ff == 4'(lht_pkg::DivSteps));
   assign status.clearing = clearing;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= in_mode;
         tag_ff  <= in_tag;
         now_ff  <= in_stamp;
         rb_ff   <= in_bucket;
      end
   end

   // stamp and pending reads are registered from the captured tag
   always_ff @(posedge clock) begin
      stamp_rd_ff <= stamp_mem[tag_idx];
      if (cmd.update && mode_ff == lht_pkg::MODE_START && tag_ok)
         stamp_mem[tag_idx] <= now_ff;
   end

   always_ff @(posedge clock) begin
      match_ff <= tag_ok && pend_mem[tag_idx];
      if (clearing) begin
         if (32'(clr_ff) < TAG_COUNT) pend_mem[TagBits'(clr_ff)] <= 1'b0;
      end else if (cmd.update && tag_ok) begin
         if (mode_ff == lht_pkg::MODE_START) pend_mem[tag_idx] <= 1'b1;
         else if (mode_ff == lht_pkg::MODE_COMPLETE && match_ff)
            pend_mem[tag_idx] <= 1'b0;
      end
   end

   // partial dividend is the remainder so far and the next 16-bit digit
   assign div_num  = {rem_ff, quo_ff[SW-1 -: DW]};
   assign div_prod = 53'(div_num) * 53'(lht_pkg::DivRecip);
   assign div_back = 26'(qd_ff) * 26'(lht_pkg::NsPerUs);
   assign div_rem  = div_num - div_back;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.div_start) begin
         quo_ff  <= now_ff - stamp_rd_ff;
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.div_step && !status.div_done) begin
         if (!step_ff[0]) begin
            qd_ff <= div_prod[lht_pkg::DivShift +: DW];
         end else begin
            rem_ff <= div_rem[9:0];
            quo_ff <= {quo_ff[SW-DW-1:0], qd_ff};
         end
         step_ff <= step_ff + 4'd1;
      end
   end

   // bit length of the quotient, capped at the top bucket
   always_comb begin
      bkt_in = '0;
      for (int i = 0; i < SW; i++) begin
         if (quo_ff[i]) bkt_in = (i + 1 >= BUCKET_COUNT - 1) ? BktCap : BktBits'(i + 1);
      end
   end

   assign rd_idx = (mode_ff == lht_pkg::MODE_COMPLETE) ? bkt_in : BktBits'(rb_ff);

   always_ff @(posedge clock) begin
      if (cmd.hist_read) begin
         bkt_ff <= bkt_in;
         hist_rd_ff <= hist_mem[rd_idx];
      end
      if (clearing) begin
         if (32'(clr_ff) < BUCKET_COUNT) hist_mem[BktBits'(clr_ff)] <= '0;
      end else if (cmd.update && mode_ff == lht_pkg::MODE_COMPLETE && match_ff) begin
         hist_mem[bkt_ff] <= (hist_rd_ff == CntMax) ? CntMax : hist_rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (clearing) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff  <= '0;
         completed_ff <= '0;
      end else if (cmd.update) begin
         if (mode_ff == lht_pkg::MODE_START && tag_ok) begin
            if (inflight_ff != CntMax) inflight_ff <= inflight_ff + 1'b1;
         end else if (mode_ff == lht_pkg::MODE_COMPLETE && match_ff) begin
            if (inflight_ff != '0) inflight_ff <= inflight_ff - 1'b1;
            if (completed_ff != CntMax) completed_ff <= completed_ff + 1'b1;
         end
      end
   end

   // result fields, registered at the update step
   logic [COUNT_WIDTH-1:0] bc_next;
   always_comb begin
      bc_next = '0;
      if (mode_ff == lht_pkg::MODE_COMPLETE && match_ff)
         bc_next = (hist_rd_ff == CntMax) ? CntMax : hist_rd_ff + 1'b1;
      else if (mode_ff == lht_pkg::MODE_READ && bkt_ok)
         bc_next = hist_rd_ff;
   end

   logic [OW+COUNT_WIDTH-1:0] bc_wide;
   assign bc_wide = {{OW{1'b0}}, bc_next};

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         out_matched <= (mode_ff == lht_pkg::MODE_COMPLETE) && match_ff;
         out_latency <= ((mode_ff == lht_pkg::MODE_COMPLETE) && match_ff)
                        ? quo_ff[lht_pkg::LatencyWidth-1:0] : '0;
         if (mode_ff == lht_pkg::MODE_COMPLETE && match_ff)
            out_bucket <= lht_pkg::BucketFieldWidth'(bkt_ff);
         else if (mode_ff == lht_pkg::MODE_READ)
            out_bucket <= rb_ff;
         else
            out_bucket <= '0;
         out_bcount <= bc_wide[OW-1:0];
      end
   end

   logic [OW+COUNT_WIDTH-1:0] if_wide, cp_wide;
   assign if_wide = {{OW{1'b0}}, inflight_ff};
   assign cp_wide = {{OW{1'b0}}, completed_ff};
   assign out_inflight  = if_wide[OW-1:0];
   assign out_completed = cp_wide[OW-1:0];
endmodule

### hdl/io_latency_histogram_tracker.sv
// top level of the io latency histogram tracker
// One beat in, one beat out, one item in the block at a time. A start, read,
// unmatched completion or unused mode steps through lookup, check, histogram
// read, update and respond before its result is registered on the output and
// the next beat can be taken. A matched completion adds the divide state
// between check and histogram read: the divide by 1000 that converts ns to us
// (four 16-bit digits through a reciprocal multiply, each an estimate step then
// a remainder step). A result still stalled on the output holds the next item
// until it drains. After reset the pending bits and histogram are cleared one
// entry a cycle, over max(TAG_COUNT, BUCKET_COUNT) entries (1024 by default),
// before the first beat is taken. The stamp table sits in a single-port memory;
// pending bits and histogram have separate read and write addresses.
module io_latency_histogram_tracker #(
   parameter int TAG_COUNT = 1024,
   parameter int BUCKET_COUNT = 64,
   parameter int COUNT_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode[1:0], request_tag[11:2], timestamp_ns[75:12], read_bucket[81:76]
   input  logic [87:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // matched[0], latency_us[55:1], bucket[61:56], bucket_count[93:62],
   // in_flight[125:94], completed_total[157:126]
   output logic [159:0] rsp_tdata
);
   lht_pkg::cmd_type cmd;
   lht_pkg::status_type status;
   logic [1:0] cur_mode;
   logic in_fire, out_free;
   logic rsp_valid_ff;
   logic matched;
   logic [54:0] lat;
   logic [5:0] bkt;
   logic [31:0] bc, inf, cmp;
   logic [159:0] data_ff;

   assign in_fire  = req_tvalid && req_tready;
   // output register free when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_tready;

   lht_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_fire(in_fire), .mode(cur_mode),
      .out_free(out_free), .status(status), .in_ready(req_tready), .cmd(cmd)
   );

   lht_datapath #(
      .TAG_COUNT(TAG_COUNT), .BUCKET_COUNT(BUCKET_COUNT), .COUNT_WIDTH(COUNT_WIDTH)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .in_mode(req_tdata[1:0]), .in_tag(req_tdata[11:2]),
      .in_stamp(req_tdata[75:12]), .in_bucket(req_tdata[81:76]),
      .status(status), .cur_mode(cur_mode),
      .out_matched(matched), .out_latency(lat), .out_bucket(bkt),
      .out_bcount(bc), .out_inflight(inf), .out_completed(cmp)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.present) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.present) data_ff <= {2'b00, cmp, inf, bc, bkt, lat, matched};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = data_ff;
endmodule

### hdl/lht_checker.sv
// port-level checker for the latency histogram tracker, with its bind
`include "io_latency_histogram_tracker_assert.svh"
module lht_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [159:0] rsp_tdata
);
   `LHT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled beat changed")
   `LHT_ASSERT_NEXT(a_no_back, clock, reset, req_tvalid && req_tready, !req_tready, "second beat taken while busy")
   `LHT_ASSERT_ALWAYS(a_unmatched_zero, clock, reset, !rsp_tvalid || rsp_tdata[0] || rsp_tdata[55:1] == 55'd0, "latency without match")
   `LHT_ASSERT_ALWAYS(a_pad_zero, clock, reset, !rsp_tvalid || rsp_tdata[159:158] == 2'b00, "padding bits set")
endmodule

bind io_latency_histogram_tracker lht_checker u_lht_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
